### rtl/core/gpda_pkg.sv
package gpda_pkg;

   // field widths
   localparam int POS_W     = 16;
   localparam int HEAD_W    = 15;
   localparam int RANGE_W   = 16;
   localparam int FWD_W     = 12;
   localparam int TURN_W    = 15;
   localparam int TST_W     = 14;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 3;

   // CORDIC datapath
   localparam int CORDIC_STEPS_DEF = 14;
   localparam int CORDIC_STEPS_MAX = 20;
   localparam int PRESCALE         = 16;
   localparam int XW               = 36;   // x/y: 17-bit offset << 16, plus gain headroom
   localparam int ZW               = 28;   // angle, 24 fraction bits
   localparam int ATAN_W           = 27;
   localparam int HALF_PI_I        = 26353589;

   localparam logic [ATAN_W-1:0] ATAN_TAB [CORDIC_STEPS_MAX] = '{
      27'd13176795, 27'd7778716, 27'd4110060, 27'd2086331, 27'd1047214,
      27'd524117,   27'd262123,  27'd131069,  27'd65536,   27'd32768,
      27'd16384,    27'd8192,    27'd4096,    27'd2048,    27'd1024,
      27'd512,      27'd256,     27'd128,     27'd64,      27'd32
   };

   // Q3.12 constants
   localparam int PI_Q12     = 12868;
   localparam int TWO_PI_Q12 = 25736;
   localparam int SPD_CRAWL  = 410;
   localparam int SPD_CRUISE = 1638;
   localparam int SPD_TURN   = 4096;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRONT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TSTOP  = 3'd4;

   localparam logic [CSR_W-1:0] FRONT_RST  = 16'd128;
   localparam logic [CSR_W-1:0] LEFT_RST   = 16'd77;
   localparam logic [CSR_W-1:0] RIGHT_RST  = 16'd77;
   localparam logic [CSR_W-1:0] ARRIVE_RST = 16'd26;
   localparam logic [TST_W-1:0] TSTOP_RST  = 14'd410;

   // obstacle override decided at the input stage
   typedef struct packed {
      logic                     fwd_set;
      logic signed [FWD_W-1:0]  fwd;
      logic                     turn_set;
      logic signed [TURN_W-1:0] turn;
   } ovr_type;

   // per-beat sideband carried alongside the CORDIC
   typedef struct packed {
      logic signed [HEAD_W:0] hsum;
      logic                   dy_nz;
      logic                   far;
      ovr_type                ovr;
   } side_type;

endpackage

### rtl/core/goto_pose_drive_with_avoidance.sv
// channel | ports                        | direction | beat
// req     | req_valid / req_stall        | in        | robot pose, target pose, five ranges
// rsp     | rsp_valid / rsp_stall        | out       | forward_speed, turn_speed
// csr     | csr_write / csr_index / data | in        | one threshold register per write
// One beat enters per cycle unless the pipeline is held; the pipeline is set by the
// unrolled CORDIC, one register stage per iteration, plus three stages before and three after.
// Reset (synchronous) clears valid bits and loads threshold defaults.
// The whole pipeline holds while a result sits in the output register under rsp_stall;
// req_stall is raised in exactly those cycles.
module goto_pose_drive_with_avoidance #(
   parameter int CORDIC_STEPS = gpda_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [gpda_pkg::POS_W-1:0]    req_robot_x,
   input  logic signed [gpda_pkg::POS_W-1:0]    req_robot_y,
   input  logic signed [gpda_pkg::HEAD_W-1:0]   req_robot_heading,
   input  logic signed [gpda_pkg::POS_W-1:0]    req_target_x,
   input  logic signed [gpda_pkg::POS_W-1:0]    req_target_y,
   input  logic signed [gpda_pkg::HEAD_W-1:0]   req_target_heading,
   input  logic [gpda_pkg::RANGE_W-1:0]         req_front_range,
   input  logic [gpda_pkg::RANGE_W-1:0]         req_left_range,
   input  logic [gpda_pkg::RANGE_W-1:0]         req_right_range,
   input  logic [gpda_pkg::RANGE_W-1:0]         req_left_mean_range,
   input  logic [gpda_pkg::RANGE_W-1:0]         req_right_mean_range,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [gpda_pkg::FWD_W-1:0]    rsp_forward_speed,
   output logic signed [gpda_pkg::TURN_W-1:0]   rsp_turn_speed,
   input  logic                                 csr_write,
   input  logic [gpda_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gpda_pkg::CSR_W-1:0]           csr_data
);
   import gpda_pkg::*;

   localparam int NSTEP  = (CORDIC_STEPS > CORDIC_STEPS_MAX) ? CORDIC_STEPS_MAX : CORDIC_STEPS;
   localparam int DW     = POS_W + 1;          // coordinate offset
   localparam int SQ_W   = 2 * POS_W;          // offset squared
   localparam int AW     = 16;                 // rounded angle, Q3.12
   localparam int EW     = 18;                 // bearing error before wrap
   localparam int SIDE_W = $bits(side_type);

   localparam logic signed [EW-1:0]     PI_E    = EW'(PI_Q12);
   localparam logic signed [EW-1:0]     NPI_E   = -EW'(PI_Q12);
   localparam logic signed [EW-1:0]     TWOPI_E = EW'(TWO_PI_Q12);
   localparam logic signed [ZW-1:0]     HPI_Z   = ZW'(HALF_PI_I);
   localparam logic signed [ZW-1:0]     RND_Z   = ZW'(2048);
   localparam logic signed [FWD_W-1:0]  CRAWL_F = FWD_W'(SPD_CRAWL);
   localparam logic signed [FWD_W-1:0]  CRUISE_F = FWD_W'(SPD_CRUISE);
   localparam logic signed [TURN_W-1:0] TURN_T  = TURN_W'(SPD_TURN);

   logic ce;

   // ---------------- configuration ----------------
   logic [CSR_W-1:0]   csr_front_ff, csr_left_ff, csr_right_ff, csr_arrive_ff;
   logic [TST_W-1:0]   csr_tstop_ff;
   logic [SQ_W-1:0]    csr_a2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_front_ff  <= FRONT_RST;
         csr_left_ff   <= LEFT_RST;
         csr_right_ff  <= RIGHT_RST;
         csr_arrive_ff <= ARRIVE_RST;
         csr_tstop_ff  <= TSTOP_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FRONT:  csr_front_ff  <= csr_data;
            CSR_LEFT:   csr_left_ff   <= csr_data;
            CSR_RIGHT:  csr_right_ff  <= csr_data;
            CSR_ARRIVE: csr_arrive_ff <= csr_data;
            CSR_TSTOP:  csr_tstop_ff  <= csr_data[TST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      csr_a2_ff <= SQ_W'(csr_arrive_ff) * SQ_W'(csr_arrive_ff);
   end

   // ---------------- stage 0: offsets, heading sum, obstacle override ----------------
   logic                     s0_valid_ff;
   logic signed [DW-1:0]     s0_dx_ff, s0_dy_ff;
   logic signed [HEAD_W:0]   s0_hsum_ff;
   ovr_type                  s0_ovr_ff, ovr_in;

   always_comb begin
      ovr_in = '0;
      if (req_front_range < csr_front_ff) begin
         ovr_in.fwd_set  = 1'b1;
         ovr_in.fwd      = CRAWL_F;
         ovr_in.turn_set = 1'b1;
         ovr_in.turn     = (req_right_mean_range < req_left_mean_range) ? -TURN_T : TURN_T;
      end else if (req_left_range < csr_left_ff) begin
         ovr_in.fwd_set = 1'b1;
         if (req_right_range < req_left_range) begin
            ovr_in.fwd = -CRAWL_F;
         end else begin
            ovr_in.fwd      = CRAWL_F;
            ovr_in.turn_set = 1'b1;
            ovr_in.turn     = TURN_T;
         end
      end else if (req_right_range < csr_right_ff) begin
         ovr_in.fwd_set = 1'b1;
         if (req_left_range < req_right_range) begin
            ovr_in.fwd = -CRAWL_F;
         end else begin
            ovr_in.fwd      = CRAWL_F;
            ovr_in.turn_set = 1'b1;
            ovr_in.turn     = -TURN_T;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (ce) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s0_dx_ff   <= DW'(req_target_x) - DW'(req_robot_x);
         s0_dy_ff   <= DW'(req_target_y) - DW'(req_robot_y);
         s0_hsum_ff <= (HEAD_W+1)'(req_robot_heading) + (HEAD_W+1)'(req_target_heading);
         s0_ovr_ff  <= ovr_in;
      end
   end

   // ---------------- stage 1: squares, quadrant pre-rotation ----------------
   logic                     s1_valid_ff;
   logic [SQ_W-1:0]          s1_dx2_ff, s1_dy2_ff;
   logic signed [XW-1:0]     s1_x_ff, s1_y_ff, px, py, s1_x_in, s1_y_in;
   logic signed [ZW-1:0]     s1_z_ff, s1_z_in;
   logic signed [2*DW-1:0]   dx2_full, dy2_full;
   logic signed [HEAD_W:0]   s1_hsum_ff;
   logic                     s1_dy_nz_ff;
   ovr_type                  s1_ovr_ff;

   assign px       = XW'(s0_dx_ff) <<< PRESCALE;
   assign py       = XW'(s0_dy_ff) <<< PRESCALE;
   assign dx2_full = (2*DW)'(s0_dx_ff) * (2*DW)'(s0_dx_ff);
   assign dy2_full = (2*DW)'(s0_dy_ff) * (2*DW)'(s0_dy_ff);

   always_comb begin
      s1_x_in = px;
      s1_y_in = py;
      s1_z_in = '0;
      if (px < 0) begin
         if (py >= 0) begin
            s1_x_in = py;
            s1_y_in = -px;
            s1_z_in = HPI_Z;
         end else begin
            s1_x_in = -py;
            s1_y_in = px;
            s1_z_in = -HPI_Z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ce) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s1_dx2_ff   <= dx2_full[SQ_W-1:0];
         s1_dy2_ff   <= dy2_full[SQ_W-1:0];
         s1_x_ff     <= s1_x_in;
         s1_y_ff     <= s1_y_in;
         s1_z_ff     <= s1_z_in;
         s1_hsum_ff  <= s0_hsum_ff;
         s1_dy_nz_ff <= (s0_dy_ff != '0);
         s1_ovr_ff   <= s0_ovr_ff;
      end
   end

   // ---------------- stage 2: arrival compare ----------------
   logic                     s2_valid_ff;
   logic signed [XW-1:0]     s2_x_ff, s2_y_ff;
   logic signed [ZW-1:0]     s2_z_ff;
   side_type                 s2_side_ff, s2_side_in;
   logic [SQ_W:0]            d2_sum;

   assign d2_sum = {1'b0, s1_dx2_ff} + {1'b0, s1_dy2_ff};

   always_comb begin
      s2_side_in.hsum  = s1_hsum_ff;
      s2_side_in.dy_nz = s1_dy_nz_ff;
      s2_side_in.far   = d2_sum > {1'b0, csr_a2_ff};
      s2_side_in.ovr   = s1_ovr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ce) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         s2_x_ff    <= s1_x_ff;
         s2_y_ff    <= s1_y_ff;
         s2_z_ff    <= s1_z_ff;
         s2_side_ff <= s2_side_in;
      end
   end

   // ---------------- CORDIC vectoring ----------------
   logic                  cd_valid;
   logic signed [ZW-1:0]  cd_z;
   logic [SIDE_W-1:0]     cd_side_raw;
   side_type              cd_side;

   gpda_cordic #(
      .NSTEP  (NSTEP),
      .SIDE_W (SIDE_W)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .ce        (ce),
      .in_valid  (s2_valid_ff),
      .in_x      (s2_x_ff),
      .in_y      (s2_y_ff),
      .in_z      (s2_z_ff),
      .in_side   (s2_side_ff),
      .out_valid (cd_valid),
      .out_z     (cd_z),
      .out_side  (cd_side_raw)
   );

   assign cd_side = side_type'(cd_side_raw);

   // ---------------- post 1: round to Q3.12, subtract headings ----------------
   logic                  p1_valid_ff;
   logic signed [EW-1:0]  p1_err_ff;
   logic                  p1_dy_nz_ff, p1_far_ff;
   ovr_type               p1_ovr_ff;
   logic signed [ZW-1:0]  z_rnd, z_sh;
   logic signed [AW-1:0]  ang;

   assign z_rnd = cd_z + RND_Z;
   assign z_sh  = z_rnd >>> 12;
   assign ang   = z_sh[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (ce) begin
         p1_valid_ff <= cd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         p1_err_ff   <= EW'(ang) - EW'(cd_side.hsum);
         p1_dy_nz_ff <= cd_side.dy_nz;
         p1_far_ff   <= cd_side.far;
         p1_ovr_ff   <= cd_side.ovr;
      end
   end

   // ---------------- post 2: wrap, saturate, arrival ----------------
   logic                     p2_valid_ff;
   logic signed [TURN_W-1:0] p2_turn_ff, p2_turn_in;
   logic signed [FWD_W-1:0]  p2_fwd_ff;
   ovr_type                  p2_ovr_ff;
   logic signed [EW-1:0]     err_w, err_s;

   always_comb begin
      if (p1_err_ff > PI_E) begin
         err_w = p1_err_ff - TWOPI_E;
      end else if (p1_err_ff < NPI_E) begin
         err_w = p1_err_ff + TWOPI_E;
      end else begin
         err_w = p1_err_ff;
      end
      if (err_w > PI_E) begin
         err_s = PI_E;
      end else if (err_w < NPI_E) begin
         err_s = NPI_E;
      end else begin
         err_s = err_w;
      end
      p2_turn_in = (p1_dy_nz_ff && p1_far_ff) ? err_s[TURN_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (ce) begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         p2_turn_ff <= p2_turn_in;
         p2_fwd_ff  <= p1_far_ff ? CRUISE_F : '0;
         p2_ovr_ff  <= p1_ovr_ff;
      end
   end

   // ---------------- output register: turn stop, obstacle override ----------------
   logic                     rsp_valid_ff;
   logic signed [FWD_W-1:0]  rsp_fwd_ff, rsp_fwd_in;
   logic signed [TURN_W-1:0] rsp_turn_ff, rsp_turn_in;
   logic signed [TURN_W-1:0] tstop;

   assign tstop = signed'(TURN_W'(csr_tstop_ff));

   always_comb begin
      rsp_fwd_in  = (p2_turn_ff >= tstop) ? '0 : p2_fwd_ff;
      rsp_turn_in = p2_turn_ff;
      if (p2_ovr_ff.fwd_set) begin
         rsp_fwd_in = p2_ovr_ff.fwd;
      end
      if (p2_ovr_ff.turn_set) begin
         rsp_turn_in = p2_ovr_ff.turn;
      end
   end

   assign ce = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ce) begin
         rsp_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         rsp_fwd_ff  <= rsp_fwd_in;
         rsp_turn_ff <= rsp_turn_in;
      end
   end

   assign req_stall         = !ce;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_forward_speed = rsp_fwd_ff;
   assign rsp_turn_speed    = rsp_turn_ff;

endmodule

### rtl/core/gpda_cordic.sv
module gpda_cordic #(
   parameter int NSTEP  = gpda_pkg::CORDIC_STEPS_DEF,
   parameter int SIDE_W = 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            ce,
   input  logic                            in_valid,
   input  logic signed [gpda_pkg::XW-1:0]  in_x,
   input  logic signed [gpda_pkg::XW-1:0]  in_y,
   input  logic signed [gpda_pkg::ZW-1:0]  in_z,
   input  logic [SIDE_W-1:0]               in_side,
   output logic                            out_valid,
   output logic signed [gpda_pkg::ZW-1:0]  out_z,
   output logic [SIDE_W-1:0]               out_side
);
   import gpda_pkg::*;

   logic                 valid_ff [NSTEP];
   logic signed [XW-1:0] x_ff     [NSTEP];
   logic signed [XW-1:0] y_ff     [NSTEP];
   logic signed [ZW-1:0] z_ff     [NSTEP];
   logic [SIDE_W-1:0]    side_ff  [NSTEP];

   for (genvar i = 0; i < NSTEP; i++) begin : g_step
      logic                 v_prev;
      logic signed [XW-1:0] x_prev, y_prev, xs, ys, x_in, y_in;
      logic signed [ZW-1:0] z_prev, z_in, ang;
      logic [SIDE_W-1:0]    side_prev;

      if (i == 0) begin : g_first
         assign v_prev    = in_valid;
         assign x_prev    = in_x;
         assign y_prev    = in_y;
         assign z_prev    = in_z;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = valid_ff[i-1];
         assign x_prev    = x_ff[i-1];
         assign y_prev    = y_ff[i-1];
         assign z_prev    = z_ff[i-1];
         assign side_prev = side_ff[i-1];
      end

      assign xs  = x_prev >>> i;
      assign ys  = y_prev >>> i;
      assign ang = signed'({1'b0, ATAN_TAB[i]});

      always_comb begin
         if (y_prev > 0) begin
            x_in = x_prev + ys;
            y_in = y_prev - xs;
            z_in = z_prev + ang;
         end else begin
            x_in = x_prev - ys;
            y_in = y_prev + xs;
            z_in = z_prev - ang;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (ce) begin
            valid_ff[i] <= v_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (ce) begin
            x_ff[i]    <= x_in;
            y_ff[i]    <= y_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[NSTEP-1];
   assign out_z     = z_ff[NSTEP-1];
   assign out_side  = side_ff[NSTEP-1];

endmodule
